@@ rtl/pnp_pkg.sv @@
package pnp_pkg;

  localparam int BYTE_W     = 8;
  localparam int COEF_W     = 24;
  localparam int WIP_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int PIDX_W     = 14;
  localparam int PIN_W      = 8;
  localparam int PROD_W     = 32;
  localparam int ROUND_BIAS  = 8;
  localparam int ROUND_SHIFT = 4;
  localparam int NUM_LANES  = 3;

  localparam logic signed [COEF_W-1:0] GAIN_RESET   = 24'sd4112;
  localparam logic signed [COEF_W-1:0] OFFSET_RESET = 24'sd0;
  localparam logic [WIP_W-1:0]         WIP_RESET    = 8'd32;
  localparam logic signed [COEF_W-1:0] NORM_MAX     = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] NORM_MIN     = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_RED,
    CFG_GAIN_GREEN,
    CFG_GAIN_BLUE,
    CFG_OFFSET_RED,
    CFG_OFFSET_GREEN,
    CFG_OFFSET_BLUE,
    CFG_WIDTH_IN_PATCHES
  } pnp_cfg_idx_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pnp_pipe_ctl_t;

endpackage

@@ rtl/pixel_normalize_patchify_core.sv @@
// Pixel normalization and patch reordering for a vision-transformer front end.
// The input channel takes one RGB pixel per transaction in raster order, with
// first_pixel marking the top-left pixel of a new image. Each result
// transaction carries the destination patch index, the position inside the
// patch and the three channels normalized to signed Q8.16 with saturation.
// Three identical channel lanes each run a multiply stage and a round, offset
// and saturate stage, while a position unit tracks column and row counters;
// the output stage merges them into one transaction.
// Throughput is one pixel per cycle while out_stall is low. The edge that
// accepts a pixel loads the multiply register; the output register loads
// from it once free, and out_valid rises with that load. While the receiver
// stalls, the output holds; an empty multiply stage still takes one more pixel,
// and then in_stall stays high. Reset clears the pipeline, the counters and
// the configuration registers (gains 4112, offsets 0, width 32 patches).
// Configuration is written through cfg_we, cfg_index and cfg_wdata while no
// transaction is in flight; the user ensures this, not the block.
module pixel_normalize_patchify_core
  import pnp_pkg::*;
#(
  parameter int PATCH_DIM  = 16,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        in_red,
  input  logic [BYTE_W-1:0]        in_green,
  input  logic [BYTE_W-1:0]        in_blue,
  input  logic                     in_first_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIDX_W-1:0]        out_patch_index,
  output logic [PIN_W-1:0]         out_pixel_in_patch,
  output logic signed [COEF_W-1:0] out_norm_red,
  output logic signed [COEF_W-1:0] out_norm_green,
  output logic signed [COEF_W-1:0] out_norm_blue,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]        cfg_wdata
);

  localparam int LW = $clog2(MAX_WIDTH + 1);
  localparam int LCW = WIP_W + $clog2(PATCH_DIM + 1) + $clog2(MAX_WIDTH + 1);
  localparam int LINE_RESET_FULL = int'(WIP_RESET) * PATCH_DIM;
  localparam int LINE_RESET = (LINE_RESET_FULL > MAX_WIDTH) ? MAX_WIDTH : LINE_RESET_FULL;

  logic signed [COEF_W-1:0] gain_r   [NUM_LANES];
  logic signed [COEF_W-1:0] offset_r [NUM_LANES];
  logic [WIP_W-1:0]         wip_r, wip_nxt;
  logic [LW-1:0]            line_len_r, line_len_nxt;
  logic [LCW-1:0]           line_calc;

  logic [BYTE_W-1:0]        lane_pix  [NUM_LANES];
  logic signed [COEF_W-1:0] lane_norm [NUM_LANES];

  pnp_pipe_ctl_t     ctl;
  logic              accept, out_free, s1_free;
  logic              s1_valid_r, s1_valid_nxt, out_valid_r, out_valid_nxt;
  logic [PIDX_W-1:0] pidx_c, s1_pidx_r, out_pidx_r;
  logic [PIN_W-1:0]  pin_c, s1_pin_r, out_pin_r;

  always_comb begin
    wip_nxt      = (cfg_wdata[WIP_W-1:0] == '0) ? WIP_W'(1) : cfg_wdata[WIP_W-1:0];
    line_calc    = LCW'(wip_nxt) * LCW'(PATCH_DIM);
    line_len_nxt = (line_calc > LCW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : line_calc[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        gain_r[i]   <= GAIN_RESET;
        offset_r[i] <= OFFSET_RESET;
      end
      wip_r      <= WIP_RESET;
      line_len_r <= LW'(LINE_RESET);
    end else if (cfg_we) begin
      unique case (pnp_cfg_idx_t'(cfg_index))
        CFG_GAIN_RED:         gain_r[0]   <= cfg_wdata;
        CFG_GAIN_GREEN:       gain_r[1]   <= cfg_wdata;
        CFG_GAIN_BLUE:        gain_r[2]   <= cfg_wdata;
        CFG_OFFSET_RED:       offset_r[0] <= cfg_wdata;
        CFG_OFFSET_GREEN:     offset_r[1] <= cfg_wdata;
        CFG_OFFSET_BLUE:      offset_r[2] <= cfg_wdata;
        CFG_WIDTH_IN_PATCHES: begin
          wip_r      <= wip_nxt;
          line_len_r <= line_len_nxt;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    s1_free       = !s1_valid_r || out_free;
    accept        = in_valid && s1_free;
    ctl.s1_load   = accept;
    ctl.s2_load   = s1_valid_r && out_free;
    s1_valid_nxt  = accept ? 1'b1 : (out_free ? 1'b0 : s1_valid_r);
    out_valid_nxt = ctl.s2_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  assign in_stall = !s1_free;

  pnp_position #(
    .PATCH_DIM  (PATCH_DIM),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (accept),
    .first_pixel    (in_first_pixel),
    .wip            (wip_r),
    .line_len       (line_len_r),
    .patch_index    (pidx_c),
    .pixel_in_patch (pin_c)
  );

  assign lane_pix[0] = in_red;
  assign lane_pix[1] = in_green;
  assign lane_pix[2] = in_blue;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pnp_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .pix    (lane_pix[g]),
      .gain   (gain_r[g]),
      .offset (offset_r[g]),
      .norm   (lane_norm[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      s1_pidx_r <= pidx_c;
      s1_pin_r  <= pin_c;
    end
    if (ctl.s2_load) begin
      out_pidx_r <= s1_pidx_r;
      out_pin_r  <= s1_pin_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_patch_index    = out_pidx_r;
  assign out_pixel_in_patch = out_pin_r;
  assign out_norm_red       = lane_norm[0];
  assign out_norm_green     = lane_norm[1];
  assign out_norm_blue      = lane_norm[2];

endmodule

@@ rtl/pnp_lane.sv @@
module pnp_lane
  import pnp_pkg::*;
(
  input  logic                     clk,
  input  pnp_pipe_ctl_t            ctl,
  input  logic [BYTE_W-1:0]        pix,
  input  logic signed [COEF_W-1:0] gain,
  input  logic signed [COEF_W-1:0] offset,
  output logic signed [COEF_W-1:0] norm
);

  localparam int RND_W = PROD_W - ROUND_SHIFT;
  localparam int SUM_W = RND_W + 1;

  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [PROD_W-1:0] biased;
  logic signed [RND_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  sum;
  logic signed [COEF_W-1:0] norm_nxt, norm_r;

  assign prod_nxt = $signed({{(PROD_W-BYTE_W){1'b0}}, pix}) * PROD_W'(gain);

  always_comb begin
    biased = prod_r + PROD_W'(ROUND_BIAS);
    rnd    = $signed(biased[PROD_W-1:ROUND_SHIFT]);
    sum    = SUM_W'(rnd) + SUM_W'(offset);
    if (sum > SUM_W'(NORM_MAX)) begin
      norm_nxt = NORM_MAX;
    end else if (sum < SUM_W'(NORM_MIN)) begin
      norm_nxt = NORM_MIN;
    end else begin
      norm_nxt = sum[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      prod_r <= prod_nxt;
    end
    if (ctl.s2_load) begin
      norm_r <= norm_nxt;
    end
  end

  assign norm = norm_r;

endmodule

@@ rtl/pnp_position.sv @@
module pnp_position
  import pnp_pkg::*;
#(
  parameter int PATCH_DIM  = 16,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int LW = $clog2(MAX_WIDTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              first_pixel,
  input  logic [WIP_W-1:0]  wip,
  input  logic [LW-1:0]     line_len,
  output logic [PIDX_W-1:0] patch_index,
  output logic [PIN_W-1:0]  pixel_in_patch
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int PSW  = $clog2(PATCH_DIM);
  localparam int IW   = ((RW + WIP_W > CW) ? RW + WIP_W : CW) + PIDX_W;
  localparam int PINW = 2 * PSW + PIN_W;

  logic [CW-1:0]  col_r, col_nxt, col_c, pcol_r, pcol_nxt, pcol_c;
  logic [RW-1:0]  row_r, row_nxt, row_c, prow_r, prow_nxt, prow_c;
  logic [PSW-1:0] cip_r, cip_nxt, cip_c, rip_r, rip_nxt, rip_c;
  logic [CW:0]    col_inc;
  logic [RW:0]    row_inc;
  logic [IW-1:0]  pidx_full;
  logic [PINW-1:0] pin_full;

  always_comb begin
    col_c  = first_pixel ? '0 : col_r;
    row_c  = first_pixel ? '0 : row_r;
    cip_c  = first_pixel ? '0 : cip_r;
    rip_c  = first_pixel ? '0 : rip_r;
    pcol_c = first_pixel ? '0 : pcol_r;
    prow_c = first_pixel ? '0 : prow_r;

    pidx_full = IW'(prow_c) * IW'(wip) + IW'(pcol_c);
    pin_full  = PINW'(rip_c) * PINW'(PATCH_DIM) + PINW'(cip_c);
    patch_index    = pidx_full[PIDX_W-1:0];
    pixel_in_patch = pin_full[PIN_W-1:0];

    col_inc = {1'b0, col_c} + (CW+1)'(1);
    row_inc = {1'b0, row_c} + (RW+1)'(1);

    col_nxt  = col_inc[CW-1:0];
    cip_nxt  = cip_c;
    pcol_nxt = pcol_c;
    row_nxt  = row_c;
    rip_nxt  = rip_c;
    prow_nxt = prow_c;

    if (col_inc >= (CW+1)'(line_len)) begin
      col_nxt  = '0;
      cip_nxt  = '0;
      pcol_nxt = '0;
      if (row_inc >= (RW+1)'(MAX_HEIGHT)) begin
        row_nxt  = '0;
        rip_nxt  = '0;
        prow_nxt = '0;
      end else begin
        row_nxt = row_inc[RW-1:0];
        if (rip_c == PSW'(PATCH_DIM - 1)) begin
          rip_nxt  = '0;
          prow_nxt = prow_c + RW'(1);
        end else begin
          rip_nxt = rip_c + PSW'(1);
        end
      end
    end else if (cip_c == PSW'(PATCH_DIM - 1)) begin
      cip_nxt  = '0;
      pcol_nxt = pcol_c + CW'(1);
    end else begin
      cip_nxt = cip_c + PSW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cip_r  <= '0;
      rip_r  <= '0;
      pcol_r <= '0;
      prow_r <= '0;
    end else if (advance) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cip_r  <= cip_nxt;
      rip_r  <= rip_nxt;
      pcol_r <= pcol_nxt;
      prow_r <= prow_nxt;
    end
  end

endmodule

@@ rtl/pnp_checker.sv @@
module pnp_checker
  import pnp_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [PIDX_W-1:0]        out_patch_index,
  input logic [PIN_W-1:0]         out_pixel_in_patch,
  input logic signed [COEF_W-1:0] out_norm_red,
  input logic signed [COEF_W-1:0] out_norm_green,
  input logic signed [COEF_W-1:0] out_norm_blue
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result transaction dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_patch_index) && $stable(out_pixel_in_patch)
      && $stable(out_norm_red) && $stable(out_norm_green) && $stable(out_norm_blue))
    else $error("Stalled result payload changed.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("Pipeline not empty after reset.");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("Input stalled while the output register is empty.");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid) || $past(in_valid))
    else $error("Input stalled with no transaction in flight.");

endmodule

bind pixel_normalize_patchify_core pnp_checker u_pnp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_patch_index    (out_patch_index),
  .out_pixel_in_patch (out_pixel_in_patch),
  .out_norm_red       (out_norm_red),
  .out_norm_green     (out_norm_green),
  .out_norm_blue      (out_norm_blue)
);

@@ tb/patch_pixel_checker.sv @@
module patch_pixel_checker
  import pnp_pkg::*;
#(
  parameter int PATCH_DIM  = 16,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_red,
  input  logic [BYTE_W-1:0]    in_green,
  input  logic [BYTE_W-1:0]    in_blue,
  input  logic                 in_first_pixel,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [PIDX_W-1:0]    out_patch_index,
  input  logic [PIN_W-1:0]     out_pixel_in_patch,
  input  logic [COEF_W-1:0]    out_norm_red,
  input  logic [COEF_W-1:0]    out_norm_green,
  input  logic [COEF_W-1:0]    out_norm_blue,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    logic [PIDX_W-1:0] patch_index;
    logic [PIN_W-1:0]  pixel_in_patch;
    logic [COEF_W-1:0] norm_red;
    logic [COEF_W-1:0] norm_green;
    logic [COEF_W-1:0] norm_blue;
  } patch_pixel_t;

  logic signed [COEF_W-1:0] gain [NUM_LANES];
  logic signed [COEF_W-1:0] offset [NUM_LANES];
  logic [WIP_W-1:0]         patch_cols;
  int                       column;
  int                       row;
  patch_pixel_t             expected_pixels [$];
  patch_pixel_t             oldest;

  function automatic logic [COEF_W-1:0] normalize_byte(logic [BYTE_W-1:0] value,
                                                       logic signed [COEF_W-1:0] scale,
                                                       logic signed [COEF_W-1:0] bias);
    longint product;
    longint sum;
    product = longint'(value) * longint'(scale);
    // Round Q.20 to Q.16 with halves going toward plus infinity.
    sum = ((product + 8) >>> 4) + longint'(bias);
    if (sum > longint'(NORM_MAX)) sum = longint'(NORM_MAX);
    if (sum < longint'(NORM_MIN)) sum = longint'(NORM_MIN);
    return sum[COEF_W-1:0];
  endfunction

  function automatic patch_pixel_t predict_pixel(logic [BYTE_W-1:0] red, logic [BYTE_W-1:0] green,
                                                 logic [BYTE_W-1:0] blue, logic first);
    patch_pixel_t result;
    int           grid;
    int           line_len;
    int           patch;
    int           position;
    grid = (patch_cols == '0) ? 1 : int'(patch_cols);
    line_len = grid * PATCH_DIM;
    if (line_len > MAX_WIDTH) line_len = MAX_WIDTH;
    if (first) begin
      column = 0;
      row = 0;
    end
    patch = (row / PATCH_DIM) * grid + column / PATCH_DIM;
    position = (row % PATCH_DIM) * PATCH_DIM + column % PATCH_DIM;
    result.patch_index = patch[PIDX_W-1:0];
    result.pixel_in_patch = position[PIN_W-1:0];
    result.norm_red = normalize_byte(red, gain[0], offset[0]);
    result.norm_green = normalize_byte(green, gain[1], offset[1]);
    result.norm_blue = normalize_byte(blue, gain[2], offset[2]);
    column++;
    if (column >= line_len) begin
      column = 0;
      row++;
      if (row >= MAX_HEIGHT) row = 0;
    end
    return result;
  endfunction

  task automatic check_field(input string field, input logic [COEF_W-1:0] want,
                             input logic [COEF_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int lane = 0; lane < NUM_LANES; lane++) begin
        gain[lane] = GAIN_RESET;
        offset[lane] = OFFSET_RESET;
      end
      patch_cols = WIP_RESET;
      column = 0;
      row = 0;
      mismatches = 0;
      expected_pixels.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_RED:         gain[0] = cfg_wdata;
          CFG_GAIN_GREEN:       gain[1] = cfg_wdata;
          CFG_GAIN_BLUE:        gain[2] = cfg_wdata;
          CFG_OFFSET_RED:       offset[0] = cfg_wdata;
          CFG_OFFSET_GREEN:     offset[1] = cfg_wdata;
          CFG_OFFSET_BLUE:      offset[2] = cfg_wdata;
          CFG_WIDTH_IN_PATCHES: patch_cols = cfg_wdata[WIP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with no pixel outstanding");
          mismatches++;
        end else begin
          oldest = expected_pixels.pop_front();
          check_field("patch_index", COEF_W'(oldest.patch_index), COEF_W'(out_patch_index));
          check_field("pixel_in_patch", COEF_W'(oldest.pixel_in_patch),
                      COEF_W'(out_pixel_in_patch));
          check_field("norm_red", oldest.norm_red, out_norm_red);
          check_field("norm_green", oldest.norm_green, out_norm_green);
          check_field("norm_blue", oldest.norm_blue, out_norm_blue);
        end
      end
      if (in_valid && !in_stall) begin
        expected_pixels.insert(expected_pixels.size(),
                               predict_pixel(in_red, in_green, in_blue, in_first_pixel));
      end
      pending <= expected_pixels.size();
    end
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import pnp_pkg::*;

  localparam int PATCH_DIM   = 16;
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [COEF_W-1:0] gain_red;
    logic [COEF_W-1:0] gain_green;
    logic [COEF_W-1:0] gain_blue;
    logic [COEF_W-1:0] offset_red;
    logic [COEF_W-1:0] offset_green;
    logic [COEF_W-1:0] offset_blue;
    logic [WIP_W-1:0]  patch_cols;
  } norm_settings_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [BYTE_W-1:0]        in_red;
  logic [BYTE_W-1:0]        in_green;
  logic [BYTE_W-1:0]        in_blue;
  logic                     in_first_pixel;
  logic                     out_valid;
  logic                     out_stall;
  logic [PIDX_W-1:0]        out_patch_index;
  logic [PIN_W-1:0]         out_pixel_in_patch;
  logic signed [COEF_W-1:0] out_norm_red;
  logic signed [COEF_W-1:0] out_norm_green;
  logic signed [COEF_W-1:0] out_norm_blue;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [COEF_W-1:0]        cfg_wdata;
  int                       mismatch_count;
  int                       pending_pixels;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pixel_normalize_patchify_core #(
    .PATCH_DIM (PATCH_DIM),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_first_pixel    (in_first_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_patch_index   (out_patch_index),
    .out_pixel_in_patch(out_pixel_in_patch),
    .out_norm_red      (out_norm_red),
    .out_norm_green    (out_norm_green),
    .out_norm_blue     (out_norm_blue),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  patch_pixel_checker #(
    .PATCH_DIM (PATCH_DIM),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_first_pixel    (in_first_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_patch_index   (out_patch_index),
    .out_pixel_in_patch(out_pixel_in_patch),
    .out_norm_red      (out_norm_red),
    .out_norm_green    (out_norm_green),
    .out_norm_blue     (out_norm_blue),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatches        (mismatch_count),
    .pending           (pending_pixels)
  );

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COEF_W-1:0] random_coef();
    int                pick;
    logic [COEF_W-1:0] value;
    pick = $urandom_range(0, 9);
    case (pick)
      0: value = NORM_MAX;
      1: value = NORM_MIN;
      2, 3: value = COEF_W'($urandom());
      default: begin
        value = COEF_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1) value = -value;
      end
    endcase
    return value;
  endfunction

  function automatic logic [BYTE_W-1:0] random_byte();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input pnp_cfg_idx_t idx, input logic [COEF_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input norm_settings_t s);
    write_reg(CFG_GAIN_RED, s.gain_red);
    write_reg(CFG_GAIN_GREEN, s.gain_green);
    write_reg(CFG_GAIN_BLUE, s.gain_blue);
    write_reg(CFG_OFFSET_RED, s.offset_red);
    write_reg(CFG_OFFSET_GREEN, s.offset_green);
    write_reg(CFG_OFFSET_BLUE, s.offset_blue);
    write_reg(CFG_WIDTH_IN_PATCHES, COEF_W'(s.patch_cols));
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input logic [BYTE_W-1:0] red, input logic [BYTE_W-1:0] green,
                            input logic [BYTE_W-1:0] blue, input logic first, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= red;
    in_green <= green;
    in_blue <= blue;
    in_first_pixel <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    int free_left;
    int hold_left;
    int results_taken;
    free_left = 0;
    hold_left = 0;
    results_taken = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results_taken++;
        // Hold off long enough that the core fills and stalls its input.
        if (results_taken == 150 || results_taken == 700) begin
          free_left = 0;
          hold_left = 160;
        end
      end
      if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 6);
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pixel_normalize_patchify_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    norm_settings_t setting;
    int             pixel_count;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_red <= '0;
    in_green <= '0;
    in_blue <= '0;
    in_first_pixel <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_GAIN_RED;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, byte extremes, alternating bit patterns, restart mid-image.
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1, sender_gap());
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, sender_gap());
    send_pixel(8'h55, 8'hAA, 8'h0F, 1'b0, sender_gap());
    send_pixel(8'hAA, 8'h55, 8'hF0, 1'b0, sender_gap());
    send_pixel(8'h80, 8'h01, 8'h7F, 1'b1, sender_gap());
    drain();

    // Saturation both ways, exact halves on blue, zero width wrapping every patch row.
    setting = '{gain_red: NORM_MAX, gain_green: NORM_MIN, gain_blue: 24'd1,
                offset_red: NORM_MAX, offset_green: NORM_MIN, offset_blue: '0,
                patch_cols: '0};
    load_settings(setting);
    for (int i = 0; i < 18; i++) begin
      send_pixel((i == 0) ? 8'hFF : random_byte(), i[0] ? 8'hFF : 8'h00, BYTE_W'(8 + 16 * i),
                 i == 0, sender_gap());
    end
    drain();

    // Negative halves round up, and a grid wider than the longest line.
    setting = '{gain_red: '1, gain_green: '1, gain_blue: '1,
                offset_red: 24'h000010, offset_green: '0, offset_blue: NORM_MIN,
                patch_cols: '1};
    load_settings(setting);
    send_pixel(8'h08, 8'h18, 8'h08, 1'b1, sender_gap());
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, sender_gap());
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, sender_gap());
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      setting.gain_red = random_coef();
      setting.gain_green = random_coef();
      setting.gain_blue = random_coef();
      setting.offset_red = random_coef();
      setting.offset_green = random_coef();
      setting.offset_blue = random_coef();
      case (phase)
        0: setting.patch_cols = 8'd1;
        1: setting.patch_cols = 8'd128;
        2: setting.patch_cols = 8'd0;
        3: setting.patch_cols = 8'd255;
        4: setting.patch_cols = 8'd2;
        5: setting.patch_cols = 8'd3;
        default: setting.patch_cols = WIP_W'($urandom_range(0, 255));
      endcase
      load_settings(setting);
      pixel_count = $urandom_range(110, 160);
      for (int i = 0; i < pixel_count; i++) begin
        send_pixel(random_byte(), random_byte(), random_byte(),
                   i == 0 || $urandom_range(0, 63) == 0, sender_gap());
      end
      drain();
    end
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("pixel_normalize_patchify_core regression: pass");
    end else begin
      $display("pixel_normalize_patchify_core regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pnp_pkg.sv
rtl/pnp_lane.sv
rtl/pnp_position.sv
rtl/pixel_normalize_patchify_core.sv
rtl/pnp_checker.sv
tb/patch_pixel_checker.sv
tb/tb.sv
